// ===== rtl/ipv6v_pkg.sv =====
// shared types, constants and character classes for the ipv6 text validator
`default_nettype none

package ipv6v_pkg;

	// parser phase, one-hot
	typedef enum logic [5:0] {
		PH_NONE         = 6'b000001,
		PH_LEAD_COLON   = 6'b000010,
		PH_AFTER_DOUBLE = 6'b000100,
		PH_IN_HEX       = 6'b001000,
		PH_IN_DEC       = 6'b010000,
		PH_AFTER_COLON  = 6'b100000
	} phase_t;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOT   = 8'h2E;

	localparam logic [3:0] GROUP_SAT     = 4'd15;
	localparam logic [2:0] GROUP_DIGITS  = 3'd4;
	localparam logic [2:0] TAIL_OCTETS   = 3'd3;
	localparam logic [8:0] OCTET_MAX     = 9'd255;
	localparam logic [8:0] OCTET_SAT     = 9'd256;
	localparam logic [4:0] GROUPS_FULL   = 5'd8;
	localparam logic [4:0] GROUPS_DOUBLE = 5'd7;
	localparam logic [4:0] TAIL_GROUPS   = 5'd2;

	// parser state carried between words
	typedef struct packed {
		phase_t     phase;
		logic [3:0] group_count;
		logic [2:0] digit_count;
		logic       double_colon;
		logic       error;
		logic       in_tail;
		logic [2:0] tail_octets;
		logic [8:0] octet_value;
		logic       octet_digit;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		phase:        PH_NONE,
		group_count:  4'd0,
		digit_count:  3'd0,
		double_colon: 1'b0,
		error:        1'b0,
		in_tail:      1'b0,
		tail_octets:  3'd0,
		octet_value:  9'd0,
		octet_digit:  1'b0
	};

	function automatic logic is_dec(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_dec(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
	endfunction

endpackage

`default_nettype wire

// ===== rtl/ipv6_text_address_validator.sv =====
// top level: input register, parser state and result register
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------
//   input   | in_valid / in_ready  | character, last_char
//   output  | out_valid / out_ready| valid_res
//
// One character per cycle. A word is held in the input register, parsed
// there, and the last character of a text loads the result register.
// Input stalls only while a finished text waits behind an unread result.
// Reset clears the parser to the start of a text and drops both registers.
`default_nettype none

module ipv6_text_address_validator
	import ipv6v_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] character,
	input  logic       last_char,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       valid_res
);

	logic         valid_s1;
	logic [7:0]   char_s1;
	logic         last_s1;
	parse_state_t state_q;
	parse_state_t state_nxt;
	logic         verdict;
	logic         out_valid_q;
	logic         valid_res_q;
	logic         advance;

	// the stage moves on unless a finished text meets a full result register
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	ipv6v_step u_step (
		.cur       (state_q),
		.character (char_s1),
		.last_char (last_s1),
		.nxt       (state_nxt),
		.verdict   (verdict)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= character;
			last_s1 <= last_char;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			valid_res_q <= verdict;
		end
	end

	assign out_valid = out_valid_q;
	assign valid_res = valid_res_q;

endmodule

`default_nettype wire

// ===== rtl/ipv6v_step.sv =====
// next-state and verdict logic for one text character
`default_nettype none

module ipv6v_step
	import ipv6v_pkg::*;
(
	input  parse_state_t cur,
	input  logic [7:0]   character,
	input  logic         last_char,
	output parse_state_t nxt,
	output logic         verdict
);

	// decimal accumulate with saturation at 256
	function automatic logic [8:0] acc(input logic [8:0] v, input logic [7:0] c);
		logic [11:0] t;
		t = 12'(v) * 12'd10 + 12'(c[3:0]);
		return (t > 12'(OCTET_SAT)) ? OCTET_SAT : t[8:0];
	endfunction

	parse_state_t s;
	logic         c_dec;
	logic         c_hex;
	logic         c_colon;
	logic         c_dot;
	logic [4:0]   groups;
	logic         ok;

	assign c_dec   = is_dec(character);
	assign c_hex   = is_hex(character);
	assign c_colon = (character == CH_COLON);
	assign c_dot   = (character == CH_DOT);

	// parse one character
	always_comb begin
		s = cur;
		if (!cur.error) begin
			if (cur.in_tail) begin
				if (c_dec) begin
					s.octet_value = acc(cur.octet_value, character);
					s.octet_digit = 1'b1;
				end else if (c_dot) begin
					if (!cur.octet_digit || cur.octet_value > OCTET_MAX ||
					    cur.tail_octets >= TAIL_OCTETS) begin
						s.error = 1'b1;
					end else begin
						s.tail_octets = cur.tail_octets + 3'd1;
						s.octet_value = 9'd0;
						s.octet_digit = 1'b0;
					end
				end else begin
					s.error = 1'b1;
				end
			end else begin
				case (cur.phase)
					PH_NONE, PH_AFTER_DOUBLE, PH_AFTER_COLON: begin
						if (c_colon && cur.phase == PH_NONE) begin
							s.phase = PH_LEAD_COLON;
						end else if (c_colon && cur.phase == PH_AFTER_COLON) begin
							if (cur.double_colon) begin
								s.error = 1'b1;
							end else begin
								s.double_colon = 1'b1;
								s.phase        = PH_AFTER_DOUBLE;
							end
						end else if (c_hex) begin
							// open a new group
							s.digit_count = 3'd1;
							s.octet_value = 9'd0;
							s.octet_digit = 1'b0;
							if (c_dec) begin
								s.phase       = PH_IN_DEC;
								s.octet_value = acc(9'd0, character);
								s.octet_digit = 1'b1;
							end else begin
								s.phase = PH_IN_HEX;
							end
						end else begin
							s.error = 1'b1;
						end
					end
					PH_LEAD_COLON: begin
						if (c_colon) begin
							s.double_colon = 1'b1;
							s.phase        = PH_AFTER_DOUBLE;
						end else begin
							s.error = 1'b1;
						end
					end
					PH_IN_HEX, PH_IN_DEC: begin
						if (c_colon) begin
							// close the group
							if (cur.group_count < GROUP_SAT) begin
								s.group_count = cur.group_count + 4'd1;
							end
							s.digit_count = 3'd0;
							s.phase       = PH_AFTER_COLON;
						end else if (c_dot && cur.phase == PH_IN_DEC) begin
							s.in_tail = 1'b1;
							if (cur.octet_value > OCTET_MAX) begin
								s.error = 1'b1;
							end else begin
								s.tail_octets = 3'd1;
								s.octet_value = 9'd0;
								s.octet_digit = 1'b0;
							end
						end else if (c_hex) begin
							if (cur.digit_count >= GROUP_DIGITS) begin
								s.error = 1'b1;
							end else begin
								s.digit_count = cur.digit_count + 3'd1;
							end
							if (cur.phase == PH_IN_DEC) begin
								if (c_dec) begin
									s.octet_value = acc(cur.octet_value, character);
									s.octet_digit = 1'b1;
								end else begin
									s.phase = PH_IN_HEX;
								end
							end
						end else begin
							s.error = 1'b1;
						end
					end
					default: begin
						s.error = 1'b1;
					end
				endcase
			end
		end
	end

	// verdict on the state after this character
	always_comb begin
		groups = 5'(s.group_count);
		ok     = 1'b0;
		if (s.in_tail) begin
			ok     = s.octet_digit && (s.octet_value <= OCTET_MAX) &&
			         (s.tail_octets == TAIL_OCTETS);
			groups = 5'(s.group_count) + TAIL_GROUPS;
		end else if (s.phase == PH_IN_HEX || s.phase == PH_IN_DEC) begin
			ok     = 1'b1;
			groups = 5'(s.group_count) + 5'd1;
		end
		if (s.error) begin
			verdict = 1'b0;
		end else if (s.double_colon) begin
			verdict = ok && (groups <= GROUPS_DOUBLE);
		end else begin
			verdict = ok && (groups == GROUPS_FULL);
		end
	end

	// a finished text leaves a clean parser
	assign nxt = last_char ? STATE_RESET : s;

endmodule

`default_nettype wire

// ===== rtl/ipv6v_checker.sv =====
// port-level checks for the ipv6 text validator, bound to the top level
`default_nettype none

module ipv6v_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] character,
	input  logic       last_char,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic       valid_res
);

	logic [1:0] pend_q;
	logic       in_word;
	logic       out_word;

	assign in_word  = in_valid && in_ready;
	assign out_word = out_valid && out_ready;

	// texts taken in whose result is not yet read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
		end else begin
			pend_q <= pend_q + 2'(in_word && last_char) - 2'(out_word);
		end
	end

	// a result only follows a finished text
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result without a finished text");

	// at most one text parsing and one result waiting
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 2'd2)
		else $error("too many texts in flight");

	// input stalls only behind a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

	// a waiting result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(valid_res))
		else $error("result changed while stalled");

	// a waiting input word holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(character) && $stable(last_char))
		else $error("input word changed while stalled");

endmodule

bind ipv6_text_address_validator ipv6v_checker u_ipv6v_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.character (character),
	.last_char (last_char),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.valid_res (valid_res)
);

`default_nettype wire
